// File: rtl/core/lcc_pkg.sv
// lcc_pkg: shared types and constants for the chunk cache controller
// used by lcc_slot_cell and lru_chunk_cache_controller
package lcc_pkg;

   localparam logic [1:0] ST_HIT    = 2'd0;
   localparam logic [1:0] ST_LOADED = 2'd1;
   localparam logic [1:0] ST_BEYOND = 2'd2;
   localparam logic [1:0] ST_FAILED = 2'd3;

   localparam logic [0:0] REG_CHUNK_BYTES   = 1'd0;
   localparam logic [0:0] REG_ARCHIVE_BYTES = 1'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_SCAN,
      S_DECIDE,
      S_RESP
   } state_type;

   // search token passed from cell to cell
   typedef struct packed {
      logic        hit;
      logic [5:0]  hit_idx;
      logic [31:0] hit_len;
      logic        empty;
      logic [5:0]  empty_idx;
      logic        old_found;
      logic [63:0] old_stamp;
      logic [5:0]  old_idx;
   } scan_type;

   // per-request command broadcast to all cells
   typedef struct packed {
      logic        touch;
      logic        fill;
      logic        kill;
      logic [5:0]  idx;
      logic [39:0] base;
      logic [31:0] len;
      logic [63:0] stamp;
   } upd_type;

endpackage

// File: rtl/core/lcc_slot_cell.sv
// lcc_slot_cell: one cache slot, compares its tag and folds into the scan token
// depends on lcc_pkg
module lcc_slot_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [39:0]       key,
   input  lcc_pkg::upd_type  upd,
   input  lcc_pkg::scan_type scan_in,
   output lcc_pkg::scan_type scan_out
);
   logic        valid_ff;
   logic [39:0] base_ff;
   logic [31:0] len_ff;
   logic [63:0] stamp_ff;
   logic        mine;

   assign mine = (upd.idx == 6'(IDX));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (mine && upd.fill) begin
         valid_ff <= 1'b1;
      end else if (mine && upd.kill) begin
         valid_ff <= 1'b0;
      end
      if (mine && upd.fill) begin
         base_ff <= upd.base;
         len_ff  <= upd.len;
      end
      if (mine && (upd.fill || upd.touch)) begin
         stamp_ff <= upd.stamp;
      end
   end

   always_comb begin
      scan_out = scan_in;
      if (valid_ff && base_ff == key && !scan_in.hit) begin
         scan_out.hit     = 1'b1;
         scan_out.hit_idx = 6'(IDX);
         scan_out.hit_len = len_ff;
      end
      if (!valid_ff && !scan_in.empty) begin
         scan_out.empty     = 1'b1;
         scan_out.empty_idx = 6'(IDX);
      end
      if (valid_ff && stamp_ff < scan_in.old_stamp) begin
         scan_out.old_found = 1'b1;
         scan_out.old_stamp = stamp_ff;
         scan_out.old_idx   = 6'(IDX);
      end
   end
endmodule

// File: rtl/core/lru_chunk_cache_controller.sv
// lru_chunk_cache_controller: fully associative chunk cache with timestamp lru
// depends on lcc_pkg and lcc_slot_cell
//
// channel | dir | ports
// req     | in  | req_valid req_ready req_file_start req_file_length req_chunk_number req_fetch_ok
// rsp     | out | rsp_valid rsp_ready rsp_status rsp_slot_index rsp_chunk_start ...
// csr     | in  | csr_valid csr_ready csr_index csr_data
//
// a request passes through these steps in order: accept, multiply, add and range
// check, slot chain scan with the slot update, response beat; the 32x32 multiply
// and the chain of NUM_SLOTS cells each have a step of their own.
// reset clears all slot valid bits and the use tick at once.
// a stalled response holds the block; req_ready is low until it is taken.
module lru_chunk_cache_controller #(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [39:0] req_file_start,
   input  logic [39:0] req_file_length,
   input  logic [31:0] req_chunk_number,
   input  logic        req_fetch_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_slot_index,
   output logic [39:0] rsp_chunk_start,
   output logic [31:0] rsp_fetch_length,
   output logic [31:0] rsp_valid_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [39:0] csr_data
);
   lcc_pkg::state_type state_ff, state_in;
   logic [31:0] chunk_ff;
   logic [39:0] arch_ff;
   logic [63:0] tick_ff;
   logic [39:0] fstart_ff, flen_ff;
   logic [31:0] cnum_ff;
   logic        ok_ff;
   logic [63:0] off_ff;
   logic [64:0] start_ff;
   logic        beyond_ff;
   logic        beyond;
   logic [40:0] remain_ff;
   lcc_pkg::scan_type scan;
   lcc_pkg::scan_type chain [NUM_SLOTS+1];
   lcc_pkg::upd_type  upd;
   logic [1:0]  st_ff;
   logic [5:0]  idx_ff;
   logic [31:0] flen_out_ff, vb_ff;
   logic [39:0] gap;
   logic [31:0] flength, stored;
   logic [5:0]  victim;

   assign req_ready = (state_ff == lcc_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == lcc_pkg::S_RESP);
   assign rsp_status = st_ff;
   assign rsp_slot_index = idx_ff[2:0];
   assign rsp_chunk_start = start_ff[39:0];
   assign rsp_fetch_length = flen_out_ff;
   assign rsp_valid_bytes = vb_ff;

   assign chain[0] = '{hit: 1'b0, hit_idx: '0, hit_len: '0, empty: 1'b0, empty_idx: '0,
                       old_found: 1'b0, old_stamp: '1, old_idx: '0};

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      lcc_slot_cell #(.IDX(g)) u_cell (
         .clock(clock), .reset(reset), .key(start_ff[39:0]), .upd(upd),
         .scan_in(chain[g]), .scan_out(chain[g+1]));
   end

   assign scan = chain[NUM_SLOTS];

   // start past the archive, either by the offset alone or after the add
   assign beyond = beyond_ff || (start_ff[64:40] != '0) || (start_ff[39:0] >= arch_ff);

   // victim: first empty, else oldest, slot 0 when no stamp below max
   assign victim = scan.empty ? scan.empty_idx
                 : (scan.old_found ? scan.old_idx : 6'd0);
   assign gap = arch_ff - start_ff[39:0];
   assign flength = ({8'd0, chunk_ff} < gap) ? chunk_ff : gap[31:0];
   assign stored = scan.hit ? scan.hit_len : flength;

   always_comb begin
      state_in = state_ff;
      upd = '{touch: 1'b0, fill: 1'b0, kill: 1'b0, idx: '0, base: start_ff[39:0],
              len: flength, stamp: tick_ff};
      unique case (state_ff)
         lcc_pkg::S_IDLE:   if (req_valid) state_in = lcc_pkg::S_MUL;
         lcc_pkg::S_MUL:    state_in = lcc_pkg::S_SCAN;
         lcc_pkg::S_SCAN:   state_in = lcc_pkg::S_DECIDE;
         lcc_pkg::S_DECIDE: begin
            state_in = lcc_pkg::S_RESP;
            if (!beyond) begin
               if (scan.hit) begin
                  upd.touch = 1'b1;
                  upd.idx   = scan.hit_idx;
               end else begin
                  upd.idx  = victim;
                  upd.fill = ok_ff;
                  upd.kill = !ok_ff;
               end
            end
         end
         lcc_pkg::S_RESP:   if (rsp_ready) state_in = lcc_pkg::S_IDLE;
         default:           state_in = lcc_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcc_pkg::S_IDLE;
         chunk_ff <= 32'd65536;
         arch_ff  <= '0;
         tick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_index == lcc_pkg::REG_CHUNK_BYTES) chunk_ff <= csr_data[31:0];
         if (csr_valid && csr_index == lcc_pkg::REG_ARCHIVE_BYTES) arch_ff <= csr_data;
         if (upd.touch || upd.fill) tick_ff <= tick_ff + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         fstart_ff <= req_file_start;
         flen_ff   <= req_file_length;
         cnum_ff   <= req_chunk_number;
         ok_ff     <= req_fetch_ok;
      end
      if (state_ff == lcc_pkg::S_MUL) begin
         off_ff <= 64'(cnum_ff) * 64'(chunk_ff);
      end
      if (state_ff == lcc_pkg::S_SCAN) begin
         start_ff  <= {1'b0, off_ff} + 65'(fstart_ff);
         beyond_ff <= (off_ff >= 64'(arch_ff));
         remain_ff <= (64'(flen_ff) > off_ff) ? 41'(64'(flen_ff) - off_ff) : '0;
      end
   end

   // the chain settles during decide, so the response fields read it directly
   always_ff @(posedge clock) begin
      if (state_ff == lcc_pkg::S_DECIDE) begin
         if (beyond) begin
            st_ff <= lcc_pkg::ST_BEYOND;
            idx_ff <= '0;
            flen_out_ff <= '0;
            vb_ff <= '0;
         end else if (scan.hit) begin
            st_ff <= lcc_pkg::ST_HIT;
            idx_ff <= scan.hit_idx;
            flen_out_ff <= '0;
            vb_ff <= (41'(stored) < remain_ff) ? stored : remain_ff[31:0];
         end else begin
            st_ff <= ok_ff ? lcc_pkg::ST_LOADED : lcc_pkg::ST_FAILED;
            idx_ff <= victim;
            flen_out_ff <= flength;
            vb_ff <= !ok_ff ? '0 : ((41'(flength) < remain_ff) ? flength : remain_ff[31:0]);
         end
      end
   end

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
   a_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lcc_pkg::S_DECIDE) |=> $stable(tick_ff)) else $error("tick moved");
endmodule

// File: dv/lcc_checker.sv
// lcc_checker: watches the csr, req and rsp channels of the chunk cache controller,
// predicts every response beat and compares it field by field; depends on lcc_pkg
module lcc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [39:0] req_file_start,
   input  logic [39:0] req_file_length,
   input  logic [31:0] req_chunk_number,
   input  logic        req_fetch_ok,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [2:0]  rsp_slot_index,
   input  logic [39:0] rsp_chunk_start,
   input  logic [31:0] rsp_fetch_length,
   input  logic [31:0] rsp_valid_bytes,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [39:0] csr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 8;

   typedef struct {
      logic [1:0]  status;
      logic [2:0]  slot;
      logic [39:0] start;
      logic [31:0] flen;
      logic [31:0] vbytes;
   } lookup_type;

   lookup_type  lookup_q[$];
   logic [31:0] chunk_sz;
   logic [39:0] arch_sz;
   logic        line_ok[SLOTS];
   logic [39:0] line_base[SLOTS];
   logic [31:0] line_len[SLOTS];
   logic [63:0] line_stamp[SLOTS];
   logic [63:0] tick;

   function automatic lookup_type cache_lookup(logic [39:0] fs, logic [39:0] fl,
                                               logic [31:0] cn, logic ok);
      lookup_type r;
      logic [63:0] off;
      logic [64:0] st;
      logic [63:0] remain;
      logic [63:0] oldest;
      logic [40:0] room;
      int hit;
      int vic;
      off = 64'(cn) * 64'(chunk_sz);
      st = 65'(fs) + 65'(off);
      remain = (64'(fl) > off) ? 64'(fl) - off : 64'd0;
      hit = -1;
      vic = 0;
      r.start = st[39:0];
      r.slot = '0;
      r.flen = '0;
      r.vbytes = '0;
      if (off >= 64'(arch_sz) || st >= 65'(arch_sz)) begin
         r.status = lcc_pkg::ST_BEYOND;
         return r;
      end
      for (int i = 0; i < SLOTS; i++)
         if (hit < 0 && line_ok[i] && line_base[i] == st[39:0]) hit = i;
      if (hit >= 0) begin
         line_stamp[hit] = tick;
         tick++;
         r.status = lcc_pkg::ST_HIT;
         r.slot = hit[2:0];
         r.vbytes = (64'(line_len[hit]) < remain) ? line_len[hit] : remain[31:0];
         return r;
      end
      // first empty line, else smallest stamp with lowest index on ties
      oldest = '1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!line_ok[i]) begin
            vic = i;
            break;
         end
         if (line_stamp[i] < oldest) begin
            oldest = line_stamp[i];
            vic = i;
         end
      end
      room = 41'(arch_sz) - 41'(st[39:0]);
      r.flen = (41'(chunk_sz) < room) ? chunk_sz : room[31:0];
      r.slot = vic[2:0];
      line_ok[vic] = 1'b0;
      if (ok) begin
         line_ok[vic] = 1'b1;
         line_base[vic] = st[39:0];
         line_len[vic] = r.flen;
         line_stamp[vic] = tick;
         tick++;
         r.status = lcc_pkg::ST_LOADED;
         r.vbytes = (64'(r.flen) < remain) ? r.flen : remain[31:0];
      end else begin
         r.status = lcc_pkg::ST_FAILED;
      end
      return r;
   endfunction

   assign pending = lookup_q.size();

   always @(posedge clock) begin
      lookup_type e;
      if (reset) begin
         chunk_sz <= 32'd65536;
         arch_sz <= '0;
         tick <= '0;
         for (int i = 0; i < SLOTS; i++) line_ok[i] <= 1'b0;
         lookup_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == lcc_pkg::REG_CHUNK_BYTES) chunk_sz <= csr_data[31:0];
            else arch_sz <= csr_data;
         end
         if (req_valid && req_ready)
            lookup_q.push_back(cache_lookup(req_file_start, req_file_length,
                                            req_chunk_number, req_fetch_ok));
         if (rsp_valid && rsp_ready) begin
            if (lookup_q.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               e = lookup_q.pop_front();
               if (rsp_status !== e.status || rsp_slot_index !== e.slot ||
                   rsp_chunk_start !== e.start || rsp_fetch_length !== e.flen ||
                   rsp_valid_bytes !== e.vbytes)
                  fail_count <= fail_count + 1;
               if (rsp_status !== e.status)
                  $error("status exp %0d got %0d", e.status, rsp_status);
               if (rsp_slot_index !== e.slot)
                  $error("slot_index exp %0d got %0d", e.slot, rsp_slot_index);
               if (rsp_chunk_start !== e.start)
                  $error("chunk_start exp %h got %h", e.start, rsp_chunk_start);
               if (rsp_fetch_length !== e.flen)
                  $error("fetch_length exp %h got %h", e.flen, rsp_fetch_length);
               if (rsp_valid_bytes !== e.vbytes)
                  $error("valid_bytes exp %h got %h", e.vbytes, rsp_valid_bytes);
            end
         end
      end
   end
endmodule

// File: dv/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for lru_chunk_cache_controller
// depends on lcc_pkg, the rtl and dv/lcc_checker.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [39:0] req_file_start = '0;
   logic [39:0] req_file_length = '0;
   logic [31:0] req_chunk_number = '0;
   logic        req_fetch_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_slot_index;
   logic [39:0] rsp_chunk_start;
   logic [31:0] rsp_fetch_length;
   logic [31:0] rsp_valid_bytes;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [39:0] csr_data = '0;
   int          fail_count;
   int          pending;
   logic        hold_off = 1'b0;
   int          idle_cycles = 0;

   logic [39:0] arch_now;
   logic [39:0] file_pool[6];

   always #5 clock = ~clock;

   lru_chunk_cache_controller dut (.*);

   lcc_checker chk (.*);

   function automatic logic [39:0] rnd40();
      return {8'($urandom_range(0, 255)), $urandom};
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // valid stays high across back-to-back beats; this task drops it only for a gap
   task automatic send_lookup(logic [39:0] fs, logic [39:0] fl, logic [31:0] cn,
                              logic ok, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_file_start <= fs;
      req_file_length <= fl;
      req_chunk_number <= cn;
      req_fetch_ok <= ok;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // valid stays high between back-to-back writes, the caller drops it
   task automatic write_reg(logic [0:0] idx, logic [39:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      if (idx == lcc_pkg::REG_ARCHIVE_BYTES) arch_now = val;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic new_phase(logic [31:0] cb, logic [39:0] ab);
      drain();
      write_reg(lcc_pkg::REG_CHUNK_BYTES, 40'(cb));
      write_reg(lcc_pkg::REG_ARCHIVE_BYTES, ab);
      csr_valid <= 1'b0;
      for (int i = 0; i < 6; i++)
         file_pool[i] = (ab == 0) ? '0 : rnd40() % ab;
   endtask

   // mostly lookups against a small set of files so lines hit and get evicted
   task automatic random_lookups(int n);
      logic [39:0] fs;
      logic [39:0] fl;
      logic [31:0] cn;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) < 7) begin
            fs = file_pool[$urandom_range(0, 5)];
            cn = $urandom_range(0, 3);
            fl = ($urandom_range(0, 3) == 0) ? rnd40() : 40'($urandom_range(0, 300000));
         end else begin
            fs = rnd40();
            fl = rnd40();
            cn = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 20);
         end
         if (k == n / 2) hold_off <= 1'b1;
         send_lookup(fs, fl, cn, $urandom_range(0, 7) != 0, gap_len());
      end
   endtask

   // response side: random stalls, plus a long hold-off each time one is requested
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            hold_off <= 1'b0;
            stall = 400;
         end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
            stall = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(1, 3);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      arch_now = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: empty archive, every lookup is beyond its end
      send_lookup('1, '1, '1, 1'b1, 0);
      send_lookup('0, '0, '0, 1'b0, 0);

      new_phase(32'd65536, 40'h10_0000);
      send_lookup(40'd0, 40'd0, 32'd0, 1'b1, 0);      // miss loads line
      send_lookup(40'd0, 40'd100, 32'd0, 1'b1, 0);    // hit, clamped by file
      send_lookup(40'd65536, 40'd0, 32'd0, 1'b0, 0);  // fetch fails
      send_lookup(40'h10_0000 - 40'd10, 40'hFF_FFFF_FFFF, 32'd0, 1'b1, 0); // clamp at end
      send_lookup('1, '0, 32'd0, 1'b1, 0);            // past archive
      send_lookup(40'd0, 40'd0, '1, 1'b1, 0);         // huge chunk number
      for (int i = 1; i <= 10; i++)                   // fill and evict by age
         send_lookup(40'(i) << 16, 40'd200000, 32'd0, 1'b1, 0);
      send_lookup(40'd0, 40'd0, 32'd0, 1'b1, 0);
      send_lookup(40'd0, 40'd131072, 32'd1, 1'b1, 0);
      random_lookups(380);

      new_phase(32'd1, 40'd64);
      random_lookups(300);
      new_phase(32'd0, 40'd1000);
      send_lookup(40'd5, 40'd10, '1, 1'b1, 0);        // zero-length line
      send_lookup(40'd5, 40'd10, 32'd3, 1'b1, 0);
      random_lookups(300);
      new_phase('1, '1);
      send_lookup('1 - 40'd1, '1, 32'd0, 1'b1, 0);
      send_lookup(40'd0, '1, 32'd255, 1'b1, 0);
      random_lookups(380);
      new_phase(32'd4096, 40'd200000);
      random_lookups(500);

      drain();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

// File: files.f
rtl/core/lcc_pkg.sv
rtl/core/lcc_slot_cell.sv
rtl/core/lru_chunk_cache_controller.sv
dv/lcc_checker.sv
dv/tb_top.sv
